/* src/arc_pkg.sv */
// Package for the ARP resolve cache: command codes, frame types and the
// beat structs passed between front end, queue and back end. No dependencies.
package arc_pkg;

    localparam logic [1:0] CMD_PKT  = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] FT_IP    = 2'd0;
    localparam logic [1:0] FT_AREQ  = 2'd1;
    localparam logic [1:0] FT_AREP  = 2'd2;

    localparam logic [1:0] REG_MAC  = 2'd0;
    localparam logic [1:0] REG_IP   = 2'd1;
    localparam logic [1:0] REG_LIFE = 2'd2;

    // work classes decided by the front end
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_LEARN  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_EMIT   = 2'd3;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] TICK_MAX  = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic        port;
        logic [1:0]  ftype;
        logic [47:0] smac;
        logic [47:0] tmac;
        logic [31:0] sip;
        logic [31:0] tip;
        logic [15:0] tag;
    } t_result;

    typedef struct packed {
        logic        port;
        logic [1:0]  op;
        logic [47:0] smac;
        logic [47:0] tmac;
        logic [31:0] sip;
        logic [31:0] tip;
        logic [15:0] tag;
    } t_job;

endpackage

/* src/arp_resolve_cache_engine_unit.sv */
// ARP resolve cache engine top level: config registers, front end, job
// queue and back end. Depends on arc_pkg, arc_front, arc_queue, arc_back.
// A lookup or ARP-reply learn scans the cache one slot per cycle in the
// back end; ticks and emitted frames skip the scan. The front end accepts
// and filters one beat per cycle while the queue is not full, into a
// two-entry queue; frames not for this station are dropped and take no
// queue entry. A result sits in an output register until popped while the
// next item is worked on.
module arp_resolve_cache_engine_unit #(
    parameter int CACHE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_frame_type,
    input  logic [47:0] i_source_mac,
    input  logic [47:0] i_target_mac,
    input  logic [31:0] i_source_ip,
    input  logic [31:0] i_target_ip,
    input  logic [15:0] i_payload_tag,
    output logic        empty,
    input  logic        pop,
    output logic        o_out_port,
    output logic [1:0]  o_out_type,
    output logic [47:0] o_out_source_mac,
    output logic [47:0] o_out_target_mac,
    output logic [31:0] o_out_source_ip,
    output logic [31:0] o_out_target_ip,
    output logic [15:0] o_out_payload_tag,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    import arc_pkg::*;

    logic [47:0] r_local_mac;
    logic [31:0] r_local_ip;
    logic [31:0] r_lifetime;

    logic    fe_valid, q_full, q_empty, be_take, res_valid;
    t_job    fe_job, q_job;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= '0;
            r_local_ip  <= '0;
            r_lifetime  <= 32'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAC:  r_local_mac <= i_cfg_data;
                REG_IP:   r_local_ip  <= i_cfg_data[31:0];
                REG_LIFE: r_lifetime  <= i_cfg_data[31:0];
                default:  ;
            endcase
        end
    end

    assign full = q_full;

    arc_front u_front (
        .i_valid       (push && !q_full),
        .i_cmd         (i_cmd),
        .i_frame_type  (i_frame_type),
        .i_source_mac  (i_source_mac),
        .i_target_mac  (i_target_mac),
        .i_source_ip   (i_source_ip),
        .i_target_ip   (i_target_ip),
        .i_payload_tag (i_payload_tag),
        .i_local_mac   (r_local_mac),
        .i_local_ip    (r_local_ip),
        .o_job_valid   (fe_valid),
        .o_job         (fe_job)
    );

    arc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_job   (fe_job),
        .o_full  (q_full),
        .i_pop   (be_take),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    arc_back #(.SLOTS(CACHE_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_take  (be_take),
        .i_local_mac (r_local_mac),
        .i_lifetime  (r_lifetime),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (pop && res_valid)
    );

    assign empty             = !res_valid;
    assign o_out_port        = res.port;
    assign o_out_type        = res.ftype;
    assign o_out_source_mac  = res.smac;
    assign o_out_target_mac  = res.tmac;
    assign o_out_source_ip   = res.sip;
    assign o_out_target_ip   = res.tip;
    assign o_out_payload_tag = res.tag;

endmodule

/* src/arc_front.sv */
// Front end: accepts input beats, filters frames not for this station and
// classifies the rest into jobs. Depends on arc_pkg.
module arc_front (
    input  logic              i_valid,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_frame_type,
    input  logic [47:0]       i_source_mac,
    input  logic [47:0]       i_target_mac,
    input  logic [31:0]       i_source_ip,
    input  logic [31:0]       i_target_ip,
    input  logic [15:0]       i_payload_tag,
    input  logic [47:0]       i_local_mac,
    input  logic [31:0]       i_local_ip,
    output logic              o_job_valid,
    output arc_pkg::t_job     o_job
);
    import arc_pkg::*;

    logic keep;
    t_job job;

    always_comb begin
        keep = 1'b0;
        job  = '0;
        case (i_cmd)
            CMD_PKT: begin
                keep     = 1'b1;
                job.op   = OP_LOOKUP;
                job.sip  = i_source_ip;
                job.tip  = i_target_ip;
                job.tag  = i_payload_tag;
            end
            CMD_RX: begin
                case (i_frame_type)
                    FT_IP: begin
                        keep      = (i_target_mac == i_local_mac);
                        job.op    = OP_EMIT;
                        job.port  = 1'b1;
                        job.smac  = i_source_mac;
                        job.tmac  = i_target_mac;
                        job.tag   = i_payload_tag;
                    end
                    FT_AREQ: begin
                        keep      = (i_target_ip == i_local_ip);
                        job.op    = OP_EMIT;
                        job.smac  = i_local_mac;
                        job.tmac  = i_source_mac;
                        job.sip   = i_target_ip;
                        job.tip   = i_source_ip;
                    end
                    FT_AREP: begin
                        keep      = (i_target_mac == i_local_mac);
                        job.op    = OP_LEARN;
                        job.smac  = i_source_mac;
                        job.sip   = i_source_ip;
                    end
                    default: keep = 1'b0;
                endcase
            end
            CMD_TICK: begin
                keep   = 1'b1;
                job.op = OP_TICK;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_job_valid = i_valid & keep;
    assign o_job       = job;

endmodule

/* src/arc_queue.sv */
// Two-entry job queue between front and back end. Depends on arc_pkg.
module arc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output arc_pkg::t_job o_job
);
    import arc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, (i_push && !o_full)} - {1'b0, (i_pop && !o_empty)};
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("full queue lost an entry");
`endif

endmodule

/* src/arc_back.sv */
// Back end: owns the cache and tick counter, scans slots one per cycle and
// writes lookup and emit results into a one-entry output register. Depends on arc_pkg.
module arc_back #(
    parameter int SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  arc_pkg::t_job   i_job,
    output logic            o_job_take,
    input  logic [47:0]     i_local_mac,
    input  logic [31:0]     i_lifetime,
    output logic            o_res_valid,
    output arc_pkg::t_result o_res,
    input  logic            i_res_take
);
    import arc_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [SLOTS-1:0] r_valid;
    logic [31:0]      r_ip  [SLOTS];
    logic [47:0]      r_mac [SLOTS];
    logic [47:0]      r_exp [SLOTS];
    logic [47:0]      r_now;

    logic [1:0]  r_state;
    t_job        r_job;
    logic [IW:0] r_idx;
    logic        r_hit;
    logic [IW-1:0] r_hit_idx;
    logic        r_free;
    logic [IW-1:0] r_free_idx;
    logic [47:0] r_rd_mac, r_rd_exp;
    logic        r_ovalid;
    t_result     r_res;
    logic [47:0] r_new_exp;

    logic [IW-1:0] cur;
    logic [48:0]   sum;
    logic          out_free;
    logic          hit_live;
    logic          res_load;
    t_result       n_res;

    assign cur      = r_idx[IW-1:0];
    assign sum      = {1'b0, r_now} + {17'd0, i_lifetime};
    assign out_free = !r_ovalid || i_res_take;
    assign hit_live = r_hit && (r_rd_exp >= r_now);
    assign res_load = (r_state == S_DONE) && (r_job.op != OP_LEARN) && out_free;
    assign o_job_take  = (r_state == S_IDLE) && i_job_valid;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

    always_comb begin
        n_res = '0;
        if (r_job.op == OP_LOOKUP) begin
            n_res.smac = i_local_mac;
            if (hit_live) begin
                n_res.ftype = FT_IP;
                n_res.tmac  = r_rd_mac;
                n_res.tag   = r_job.tag;
            end else begin
                n_res.ftype = FT_AREQ;
                n_res.tmac  = MAC_BCAST;
                n_res.sip   = r_job.sip;
                n_res.tip   = r_job.tip;
            end
        end else begin
            n_res.port  = r_job.port;
            n_res.ftype = r_job.port ? FT_IP : FT_AREP;
            n_res.smac  = r_job.smac;
            n_res.tmac  = r_job.tmac;
            n_res.sip   = r_job.port ? 32'd0 : r_job.sip;
            n_res.tip   = r_job.port ? 32'd0 : r_job.tip;
            n_res.tag   = r_job.port ? r_job.tag : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job     <= i_job;
            r_new_exp <= sum[48] ? TICK_MAX : sum[47:0];
        end
        if (r_state == S_SCAN && r_idx < (IW+1)'(SLOTS)) begin
            if (r_valid[cur] && !r_hit && r_ip[cur] ==
                ((r_job.op == OP_LOOKUP) ? r_job.tip : r_job.sip)) begin
                r_hit_idx <= cur;
            end
            if (!r_valid[cur] && !r_free) r_free_idx <= cur;
        end
        if (r_state == S_RD) begin
            r_rd_mac <= r_mac[r_hit_idx];
            r_rd_exp <= r_exp[r_hit_idx];
        end
        if (r_state == S_DONE && r_job.op == OP_LEARN) begin
            if (r_hit) begin
                r_exp[r_hit_idx] <= r_new_exp;
            end else if (r_free) begin
                r_ip[r_free_idx]  <= r_job.sip;
                r_mac[r_free_idx] <= r_job.smac;
                r_exp[r_free_idx] <= r_new_exp;
            end
        end
        if (res_load) r_res <= n_res;
    end

    // ARP request jobs carry the asked IP (local_ip) in sip and the
    // requester IP in tip.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_now    <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_ovalid <= res_load || (r_ovalid && !i_res_take);
            case (r_state)
                S_IDLE: begin
                    if (o_job_take) begin
                        r_idx  <= '0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        if (i_job.op == OP_TICK) begin
                            if (r_now != TICK_MAX) r_now <= r_now + 48'd1;
                        end else if (i_job.op == OP_EMIT) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < (IW+1)'(SLOTS)) begin
                        if (r_valid[cur] && r_ip[cur] ==
                            ((r_job.op == OP_LOOKUP) ? r_job.tip : r_job.sip)) begin
                            r_hit <= 1'b1;
                        end
                        if (!r_valid[cur]) r_free <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_DONE;
                S_DONE: begin
                    if (r_job.op == OP_LEARN) begin
                        if (!r_hit && r_free) r_valid[r_free_idx] <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        if (r_job.op == OP_LOOKUP && r_hit && !hit_live) begin
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_res_take) |=> r_ovalid)
        else $error("result dropped");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> r_state == S_IDLE)
        else $error("job taken while busy");
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_now >= $past(r_now) || $past(!i_rst_n))
        else $error("tick counter went back");
`endif

endmodule
